[src/sbac_pkg.sv]
package sbac_pkg;

    localparam int unsigned MASK_W = 32;
    localparam int unsigned DEV_W  = 5;
    localparam int unsigned CHAN_W = 4;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [CODE_W-1:0] CODE_GLOBAL   = 8'h00;
    localparam logic [CODE_W-1:0] CODE_LISTEN   = 8'h20;
    localparam logic [CODE_W-1:0] CODE_UNLISTEN = 8'h3F;
    localparam logic [CODE_W-1:0] CODE_TALK     = 8'h40;
    localparam logic [CODE_W-1:0] CODE_UNTALK   = 8'h5F;
    localparam logic [CODE_W-1:0] CODE_REOPEN   = 8'h60;
    localparam logic [CODE_W-1:0] CODE_CLOSE    = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_OPEN     = 8'hF0;
    localparam logic [CHAN_W-1:0] CMD_CHAN      = 4'd15;

    localparam logic [DATA_W-1:0] MASK_RESET = 32'h0000_0000;

    // register index within the config space
    localparam logic REG_MASK = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ERROR   = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_OFFLINE = 2'd3
    } rx_status_t;

    typedef enum logic [1:0] {
        OUT_IDLE    = 2'd0,
        OUT_PROCESS = 2'd1,
        OUT_ERROR   = 2'd2,
        OUT_OFFLINE = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [CODE_W-1:0] primary;
        logic [CODE_W-1:0] secondary;
        logic [DEV_W-1:0]  device;
        logic [CHAN_W-1:0] channel;
    } record_t;

    typedef struct packed {
        logic     done;
        outcome_t outcome;
        record_t  rec;
    } dec_t;

endpackage

[src/sbac_if.sv]
interface sbac_in_if;
    import sbac_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] command_byte;
    logic [1:0]        receive_status;

    modport source (output valid, output command_byte, output receive_status, input ready);
    modport sink   (input valid, input command_byte, input receive_status, output ready);
endinterface

interface sbac_out_if;
    import sbac_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        outcome;
    logic [CODE_W-1:0] primary_code;
    logic [CODE_W-1:0] secondary_code;
    logic [DEV_W-1:0]  device_number;
    logic [CHAN_W-1:0] channel_number;

    modport source (
        output valid, output outcome, output primary_code, output secondary_code,
        output device_number, output channel_number, input ready
    );
    modport sink (
        input valid, input outcome, input primary_code, input secondary_code,
        input device_number, input channel_number, output ready
    );
endinterface

[src/serial_bus_attention_command_decoder_unit.sv]
// Attention-command decoder for a serial peripheral bus.
//
// in_ch carries one beat per byte received under attention: command_byte and
// receive_status. out_ch carries one beat each time a byte ends a command
// sequence: outcome plus the command record (primary/secondary code, device,
// channel). Bytes that open or continue a sequence (LISTEN, TALK, unused
// classes) produce no out beat.
// The APB port holds one register, enabled_device_mask at byte address 0.
//
// Timing: an input beat lands in the input register, is decoded there and the
// result lands in the output register; out_ch.valid follows once the byte has
// passed both registers and no held result blocks it. Throughput is one byte
// per cycle while no held result blocks a byte; the decode is a single level
// of compare/select logic between the two registers.
// Backpressure: while out_ch is stalled a held result blocks only a byte that
// would produce another result; in_ch.ready falls when the input register
// is full and cannot drain. The next byte is still taken while the result
// waits in the output register.
// Reset clears both pipeline valids, the command record and the mask.
module serial_bus_attention_command_decoder_unit
    import sbac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sbac_in_if.sink           in_ch,
    sbac_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [MASK_W-1:0] mask;

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CODE_W-1:0] in_byte_reg;
    logic [1:0]        in_status_reg;

    // command record, advanced as each byte leaves the input stage
    record_t           rec_reg;
    record_t           rec_next;

    // output stage
    logic              out_valid_reg;
    logic              out_valid_next;
    outcome_t          out_outcome_reg;
    record_t           out_rec_reg;

    dec_t              dec;
    logic              in_fire;
    logic              dec_fire;

    sbac_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mask    (mask)
    );

    sbac_decode u_decode (
        .command_byte   (in_byte_reg),
        .receive_status (in_status_reg),
        .rec            (rec_reg),
        .mask           (mask),
        .dec            (dec)
    );

    // a byte that yields no result drains even when the output is stalled
    assign dec_fire    = in_valid_reg && (!dec.done || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || dec_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (dec_fire)
        begin
            in_valid_next = 1'b0;
        end

        rec_next = dec_fire ? dec.rec : rec_reg;

        out_valid_next = out_valid_reg;
        if (dec_fire && dec.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rec_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            rec_reg       <= rec_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg   <= in_ch.command_byte;
            in_status_reg <= in_ch.receive_status;
        end
        if (dec_fire && dec.done)
        begin
            out_outcome_reg <= dec.outcome;
            out_rec_reg     <= dec.rec;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.outcome        = out_outcome_reg;
    assign out_ch.primary_code   = out_rec_reg.primary;
    assign out_ch.secondary_code = out_rec_reg.secondary;
    assign out_ch.device_number  = out_rec_reg.device;
    assign out_ch.channel_number = out_rec_reg.channel;

endmodule

[src/sbac_cfg.sv]
module sbac_cfg
    import sbac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [MASK_W-1:0] mask
);

    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              hit;

    // byte address bits [1:0] are ignored; bit 2 selects the register
    assign hit    = (paddr[ADDR_W-1] == REG_MASK);
    assign pready = 1'b1;

    always_comb
    begin
        mask_next = mask_reg;
        if (psel && penable && pwrite && hit)
        begin
            mask_next = pwdata[MASK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET[MASK_W-1:0];
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign prdata = hit ? mask_reg : '0;
    assign mask   = mask_reg;

endmodule

[src/sbac_decode.sv]
module sbac_decode
    import sbac_pkg::*;
(
    input  logic [CODE_W-1:0] command_byte,
    input  logic [1:0]        receive_status,
    input  record_t           rec,
    input  logic [MASK_W-1:0] mask,
    output dec_t              dec
);

    logic [CODE_W-1:0] cls;
    logic [CHAN_W-1:0] low;
    record_t           rec_upd;
    outcome_t          oc;
    logic              done;

    always_comb
    begin
        low     = command_byte[CHAN_W-1:0];
        cls     = {command_byte[CODE_W-1:CHAN_W], {CHAN_W{1'b0}}};
        rec_upd = rec;
        oc      = OUT_IDLE;
        done    = 1'b1;

        case (rx_status_t'(receive_status))
            ST_OFFLINE: oc = OUT_OFFLINE;
            ST_ERROR:   oc = OUT_ERROR;
            ST_EMPTY:   oc = OUT_IDLE;
            default:
            begin
                // unlisten and untalk match on the whole byte only
                if (command_byte == CODE_UNLISTEN || command_byte == CODE_UNTALK)
                begin
                    cls = command_byte;
                end
                case (cls)
                    CODE_GLOBAL:
                    begin
                        rec_upd.primary = CODE_GLOBAL;
                        rec_upd.device  = {1'b0, low};
                    end
                    CODE_LISTEN, CODE_TALK:
                    begin
                        rec_upd.primary   = cls;
                        rec_upd.device    = {1'b0, low};
                        rec_upd.secondary = CODE_REOPEN;
                        rec_upd.channel   = CMD_CHAN;
                        done              = 1'b0;
                    end
                    CODE_UNLISTEN:
                    begin
                        rec_upd.primary   = CODE_UNLISTEN;
                        rec_upd.secondary = '0;
                        oc                = OUT_PROCESS;
                    end
                    CODE_UNTALK:
                    begin
                        rec_upd.primary   = CODE_UNTALK;
                        rec_upd.secondary = '0;
                    end
                    CODE_OPEN, CODE_REOPEN, CODE_CLOSE:
                    begin
                        rec_upd.secondary = cls;
                        rec_upd.channel   = low;
                        oc                = OUT_PROCESS;
                    end
                    default: done = 1'b0;   // unused class: no change
                endcase
            end
        endcase

        // end of sequence: gate by device enable, drop record unless processing
        if (done)
        begin
            if (!mask[rec_upd.device])
            begin
                oc = OUT_IDLE;
            end
            if (oc != OUT_PROCESS)
            begin
                rec_upd = '0;
            end
        end

        dec.done    = done;
        dec.outcome = oc;
        dec.rec     = rec_upd;
    end

endmodule
